>>> hw/rtl/ioc_pkg.sv
// ----------------------------------------------------------------------------
// ioc_pkg
// Shared widths, codes and types of the I/O request coalescer.
// ----------------------------------------------------------------------------
package ioc_pkg;

  localparam int ADDR_W     = 64;
  localparam int LEN_W      = 32;
  localparam int OFF_W      = 63;
  localparam int SEG_LEN_W  = 48;
  localparam int FEND_W     = 64;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_CONTINUE      = 2'd0,
    KIND_FILE_BLOCK    = 2'd1,
    KIND_FINISH        = 2'd2,
    KIND_CONTIG_FINISH = 2'd3
  } seg_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILE_OFFSET_MODE = 1'd0,
    REG_BUFFER_INPUT     = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic file_offset_mode;
    logic buffer_input;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0]    addr;
    logic [SEG_LEN_W-1:0] length;
    logic [OFF_W-1:0]     offset;
    seg_kind_t            kind;
    logic                 last;
  } seg_t;

  // up to two results per request
  typedef struct packed {
    logic [1:0] cnt;
    seg_t       seg0;
    seg_t       seg1;
  } seg_push_t;

endpackage

>>> hw/rtl/ioc_ifs.sv
// ----------------------------------------------------------------------------
// ioc channel interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ioc_req_if;
  import ioc_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] buf_addr;
  logic [LEN_W-1:0]  item_length;
  logic [OFF_W-1:0]  file_offset;
  logic              last_item;

  modport source (output valid, buf_addr, item_length, file_offset, last_item,
                  input ready);
  modport sink   (input valid, buf_addr, item_length, file_offset, last_item,
                  output ready);
endinterface

interface ioc_seg_if;
  import ioc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ADDR_W-1:0]    seg_addr;
  logic [SEG_LEN_W-1:0] seg_length;
  logic [OFF_W-1:0]     seg_offset;
  logic [1:0]           seg_kind;
  logic                 seg_last;

  modport source (output valid, seg_addr, seg_length, seg_offset, seg_kind, seg_last,
                  input ready);
  modport sink   (input valid, seg_addr, seg_length, seg_offset, seg_kind, seg_last,
                  output ready);
endinterface

interface ioc_cfg_if;
  import ioc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, idx, wdata, input ready);
  modport sink   (input valid, idx, wdata, output ready);
endinterface

>>> hw/rtl/ioc_cfg_regs.sv
// ----------------------------------------------------------------------------
// ioc_cfg_regs
// Configuration registers of the coalescer, written over the config channel.
// ----------------------------------------------------------------------------
module ioc_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  ioc_cfg_if.sink        cfg_chan,
  output ioc_pkg::cfg_t  cfg
);
  import ioc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_chan.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      case (cfg_reg_t'(cfg_chan.idx))
        REG_FILE_OFFSET_MODE: cfg_nxt.file_offset_mode = cfg_chan.wdata[0];
        REG_BUFFER_INPUT:     cfg_nxt.buffer_input     = cfg_chan.wdata[0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> hw/rtl/ioc_merge.sv
// ----------------------------------------------------------------------------
// ioc_merge
// Input register and run tracking: decides per request whether it extends
// the open run, closes it, or finishes the list.
// ----------------------------------------------------------------------------
module ioc_merge (
  input  logic               clk,
  input  logic               rst_n,
  ioc_req_if.sink            in_chan,
  input  ioc_pkg::cfg_t      cfg,
  input  logic               room,
  output ioc_pkg::seg_push_t push
);
  import ioc_pkg::*;

  // input register
  logic              s1_valid_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [LEN_W-1:0]  s1_len_r;
  logic [OFF_W-1:0]  s1_off_r;
  logic              s1_last_r;

  // run state
  logic                 run_open_r, run_open_nxt;
  logic                 run_multi_r, run_multi_nxt;
  logic [ADDR_W-1:0]    run_addr_r, run_addr_nxt;
  logic [OFF_W-1:0]     run_off_r, run_off_nxt;
  logic [SEG_LEN_W-1:0] run_bytes_r, run_bytes_nxt;
  logic [ADDR_W-1:0]    prev_buf_end_r;
  logic [FEND_W-1:0]    prev_file_end_r;

  logic                 advance;
  logic                 buf_ok;
  logic                 file_ok;
  logic                 file_break;
  logic                 close;
  logic [SEG_LEN_W:0]   bytes_sum;
  logic [SEG_LEN_W-1:0] bytes_sat;
  seg_kind_t            close_kind;
  seg_t                 closed_seg;
  seg_t                 final_seg;

  assign advance       = s1_valid_r && room;
  assign in_chan.ready = !s1_valid_r || room;

  assign buf_ok     = (prev_buf_end_r == s1_addr_r);
  assign file_ok    = (prev_file_end_r == {1'b0, s1_off_r});
  assign file_break = cfg.file_offset_mode && !file_ok;
  assign close      = run_open_r && (file_break || !buf_ok);

  assign bytes_sum = {1'b0, run_bytes_r} + (SEG_LEN_W+1)'(s1_len_r);
  assign bytes_sat = bytes_sum[SEG_LEN_W] ? {SEG_LEN_W{1'b1}} : bytes_sum[SEG_LEN_W-1:0];

  always_comb begin
    if (file_break || cfg.buffer_input) begin
      close_kind = KIND_CONTINUE;
    end else begin
      close_kind = KIND_FILE_BLOCK;
    end
  end

  always_comb begin
    if (!run_open_r || close) begin
      run_addr_nxt  = s1_addr_r;
      run_off_nxt   = s1_off_r;
      run_bytes_nxt = SEG_LEN_W'(s1_len_r);
      run_multi_nxt = 1'b0;
    end else begin
      run_addr_nxt  = run_addr_r;
      run_off_nxt   = run_off_r;
      run_bytes_nxt = bytes_sat;
      run_multi_nxt = 1'b1;
    end
    run_open_nxt = !s1_last_r;
  end

  always_comb begin
    closed_seg.addr   = run_addr_r;
    closed_seg.length = run_bytes_r;
    closed_seg.offset = run_off_r;
    closed_seg.kind   = close_kind;
    closed_seg.last   = 1'b0;

    final_seg.addr   = run_addr_nxt;
    final_seg.length = run_bytes_nxt;
    final_seg.offset = run_off_nxt;
    final_seg.kind   = run_multi_nxt ? KIND_CONTIG_FINISH : KIND_FINISH;
    final_seg.last   = 1'b1;

    push.seg0 = close ? closed_seg : final_seg;
    push.seg1 = final_seg;
    if (!advance) begin
      push.cnt = 2'd0;
    end else begin
      push.cnt = 2'({1'b0, close} + {1'b0, s1_last_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_addr_r <= in_chan.buf_addr;
      s1_len_r  <= in_chan.item_length;
      s1_off_r  <= in_chan.file_offset;
      s1_last_r <= in_chan.last_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_open_r      <= 1'b0;
      run_multi_r     <= 1'b0;
      run_addr_r      <= '0;
      run_off_r       <= '0;
      run_bytes_r     <= '0;
      prev_buf_end_r  <= '0;
      prev_file_end_r <= '0;
    end else if (advance) begin
      run_open_r      <= run_open_nxt;
      run_multi_r     <= run_multi_nxt && !s1_last_r;
      run_addr_r      <= run_addr_nxt;
      run_off_r       <= run_off_nxt;
      run_bytes_r     <= run_bytes_nxt;
      prev_buf_end_r  <= s1_addr_r + ADDR_W'(s1_len_r);
      // file end kept one bit wider so an end past the offset range never matches
      prev_file_end_r <= {1'b0, s1_off_r} + FEND_W'(s1_len_r);
    end
  end

  a_last_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_last_r |=> !run_open_r && !run_multi_r)
    else $error("run still open after last request");

  a_two_needs_last: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt == 2'd2 |-> push.seg1.last && !push.seg0.last)
    else $error("second result without list end");

  a_no_push_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |-> push.cnt == 2'd0)
    else $error("result pushed without advancing");

  a_multi_needs_open: assert property (@(posedge clk) disable iff (!rst_n)
    run_multi_r |-> run_open_r)
    else $error("multi-element run with no open run");

endmodule

>>> hw/rtl/ioc_seg_fifo.sv
// ----------------------------------------------------------------------------
// ioc_seg_fifo
// Result queue: takes up to two results a cycle if room, one a cycle if ready.
// ----------------------------------------------------------------------------
module ioc_seg_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  ioc_pkg::seg_push_t push,
  output logic              room,
  ioc_seg_if.source         out_chan
);
  import ioc_pkg::*;

  seg_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_r, wptr_nxt;
  logic [FIFO_PTR_W-1:0] rptr_r, rptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;
  logic [FIFO_PTR_W-1:0] wptr_plus1;
  logic                  pop;
  seg_t                  head;

  assign room       = (count_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign pop        = out_chan.valid && out_chan.ready;
  assign wptr_plus1 = wptr_r + FIFO_PTR_W'(1);
  assign head       = mem[rptr_r];

  assign out_chan.valid      = (count_r != '0);
  assign out_chan.seg_addr   = head.addr;
  assign out_chan.seg_length = head.length;
  assign out_chan.seg_offset = head.offset;
  assign out_chan.seg_kind   = head.kind;
  assign out_chan.seg_last   = head.last;

  always_comb begin
    wptr_nxt  = wptr_r + FIFO_PTR_W'(push.cnt);
    rptr_nxt  = pop ? rptr_r + FIFO_PTR_W'(1) : rptr_r;
    count_nxt = count_r + FIFO_CNT_W'(push.cnt) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wptr_r] <= push.seg0;
    end
    if (push.cnt == 2'd2) begin
      mem[wptr_plus1] <= push.seg1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    push.cnt != 2'd0 |-> room)
    else $error("push into full result queue");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == FIFO_CNT_W'(FIFO_DEPTH)) |-> wptr_r == rptr_r)
    else $error("queue pointers disagree with count");

endmodule

>>> hw/rtl/io_request_coalescer_unit.sv
// ----------------------------------------------------------------------------
// io_request_coalescer_unit
// Merges a sorted stream of I/O requests into contiguous runs.
//
//   channel   dir  handshake      payload
//   in_chan   in   valid/ready    buf_addr, item_length, file_offset, last_item
//   out_chan  out  valid/ready    seg_addr, seg_length, seg_offset, seg_kind, seg_last
//   cfg_chan  in   valid/ready    idx (register), wdata
//
// one request per cycle while the result queue has room; a request is registered
// in the input register and merged there; its results go through the result queue
// a request may push two results into the 4-entry result queue, which drains
// one per cycle while out_chan.ready is high, so two-result streams are throttled
// in_chan.ready drops while a request waits in the input register and the
// queue holds more than two
// synchronous active-low reset clears run state, queue and config registers
// ----------------------------------------------------------------------------
module io_request_coalescer_unit (
  input  logic       clk,
  input  logic       rst_n,
  ioc_req_if.sink    in_chan,
  ioc_seg_if.source  out_chan,
  ioc_cfg_if.sink    cfg_chan
);
  import ioc_pkg::*;

  cfg_t      cfg;
  seg_push_t push;
  logic      room;

  ioc_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  ioc_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .cfg     (cfg),
    .room    (room),
    .push    (push)
  );

  ioc_seg_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .out_chan (out_chan)
  );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// io_request_coalescer_unit testbench
// Feeds request lists into the coalescer, predicts the merged runs in a local
// model and compares every result field. The request and result sides idle
// at random. One long receiver hold-off fills the result queue. All four
// register settings are used.
// ----------------------------------------------------------------------------
module testbench;
  import ioc_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [OFF_W-1:0]  off;
    logic              is_last;
  } io_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ioc_req_if req_if ();
  ioc_seg_if seg_if ();
  ioc_cfg_if cfg_if ();

  io_request_coalescer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (seg_if),
    .cfg_chan (cfg_if)
  );

  always #4 clk = ~clk;

  // requests waiting to be offered and runs waiting to come out
  io_req_t req_pend_q[$];
  seg_t    seg_exp_q[$];
  int      err_cnt = 0;
  int      req_cnt = 0;

  // register copies and run state of the local model
  logic                 m_fom = 1'b0;
  logic                 m_bi = 1'b0;
  logic                 run_open = 1'b0;
  logic                 run_multi = 1'b0;
  logic [ADDR_W-1:0]    run_addr = '0;
  logic [OFF_W-1:0]     run_off = '0;
  logic [SEG_LEN_W-1:0] run_bytes = '0;
  logic [ADDR_W-1:0]    buf_end = '0;
  logic [FEND_W-1:0]    file_end = '0;

  // generator view of where the previous request ended
  logic [ADDR_W-1:0] gen_buf_end = '0;
  logic [FEND_W-1:0] gen_file_end = '0;
  int                gen_cnt = 0;

  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int hold_cnt = 0;
  bit hold_done = 1'b0;

  task automatic emit_seg(input seg_kind_t kind, input logic is_last);
    seg_t s;
    s.addr   = run_addr;
    s.length = run_bytes;
    s.offset = run_off;
    s.kind   = kind;
    s.last   = is_last;
    seg_exp_q.push_back(s);
  endtask

  task automatic open_run(input io_req_t r);
    run_open  = 1'b1;
    run_multi = 1'b0;
    run_addr  = r.addr;
    run_off   = r.off;
    run_bytes = SEG_LEN_W'(r.len);
  endtask

  task automatic coalesce_req(input io_req_t r);
    logic [SEG_LEN_W:0] sum;
    if (!run_open) begin
      open_run(r);
    end else if (m_fom && file_end != {1'b0, r.off}) begin
      emit_seg(KIND_CONTINUE, 1'b0);
      open_run(r);
    end else if (buf_end != r.addr) begin
      emit_seg(m_bi ? KIND_CONTINUE : KIND_FILE_BLOCK, 1'b0);
      open_run(r);
    end else begin
      sum = {1'b0, run_bytes} + (SEG_LEN_W + 1)'(r.len);
      run_bytes = sum[SEG_LEN_W] ? '1 : sum[SEG_LEN_W-1:0];
      run_multi = 1'b1;
    end
    buf_end  = r.addr + ADDR_W'(r.len);
    file_end = {1'b0, r.off} + FEND_W'(r.len);
    if (r.is_last) begin
      emit_seg(run_multi ? KIND_CONTIG_FINISH : KIND_FINISH, 1'b1);
      run_open  = 1'b0;
      run_multi = 1'b0;
    end
  endtask

  task automatic chk(input string name, input logic [63:0] exp_v, input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // request driver
  always @(posedge clk) begin : req_drv
    io_req_t cur;
    logic    nxt_valid;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      nxt_valid = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        cur.addr    = req_if.buf_addr;
        cur.len     = req_if.item_length;
        cur.off     = req_if.file_offset;
        cur.is_last = req_if.last_item;
        coalesce_req(cur);
        req_cnt <= req_cnt + 1;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_pend_q.size() > 0) begin
          cur = req_pend_q.pop_front();
          req_if.buf_addr    <= cur.addr;
          req_if.item_length <= cur.len;
          req_if.file_offset <= cur.off;
          req_if.last_item   <= cur.is_last;
          nxt_valid = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      req_if.valid <= nxt_valid;
    end
  end

  // long receiver hold-off, once, while requests keep coming
  always @(posedge clk) begin
    if (rst_n) begin
      if (!hold_done && req_cnt >= 200) begin
        hold_cnt  <= 400;
        hold_done <= 1'b1;
      end else if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : seg_mon
    seg_t exp_seg;
    logic rdy;
    if (!rst_n) begin
      seg_if.ready <= 1'b0;
    end else begin
      if (seg_if.valid && seg_if.ready) begin
        if (seg_exp_q.size() == 0) begin
          $error("unexpected result: seg_addr %h seg_kind %0d", seg_if.seg_addr,
                 seg_if.seg_kind);
          err_cnt++;
        end else begin
          exp_seg = seg_exp_q.pop_front();
          chk("seg_addr", exp_seg.addr, seg_if.seg_addr);
          chk("seg_length", 64'(exp_seg.length), 64'(seg_if.seg_length));
          chk("seg_offset", 64'(exp_seg.offset), 64'(seg_if.seg_offset));
          chk("seg_kind", 64'(exp_seg.kind), 64'(seg_if.seg_kind));
          chk("seg_last", 64'(exp_seg.last), 64'(seg_if.seg_last));
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        2: rdy = ($urandom_range(0, 3) == 0);
        default: rdy = ~seg_if.ready;
      endcase
      seg_if.ready <= rdy && (hold_cnt == 0);
    end
  end

  task automatic add_req(input logic [ADDR_W-1:0] a, input logic [LEN_W-1:0] l,
                         input logic [OFF_W-1:0] o, input logic is_last);
    io_req_t r;
    r.addr    = a;
    r.len     = l;
    r.off     = o;
    r.is_last = is_last;
    req_pend_q.push_back(r);
    gen_buf_end  = a + ADDR_W'(l);
    gen_file_end = {1'b0, o} + FEND_W'(l);
    gen_cnt++;
  endtask

  task automatic add_contig(input logic [LEN_W-1:0] l, input logic is_last);
    add_req(gen_buf_end, l, gen_file_end[OFF_W-1:0], is_last);
  endtask

  function automatic logic [ADDR_W-1:0] rand_addr();
    logic [ADDR_W-1:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) r[ADDR_W-1:16] = '1;
    return r;
  endfunction

  function automatic logic [OFF_W-1:0] rand_off();
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) r[OFF_W-1:16] = '1;
    return r[OFF_W-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return $urandom_range(0, 4096);
    if (sel < 70) return $urandom_range(0, 65535);
    if (sel < 88) return $urandom;
    if (sel < 94) return '0;
    return '1;
  endfunction

  // one list: mostly contiguous requests, some breaks, a few lists left open
  task automatic push_rand_list();
    int                n;
    int                sel;
    logic [ADDR_W-1:0] a;
    logic [OFF_W-1:0]  o;
    logic [LEN_W-1:0]  l;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
    for (int i = 0; i < n; i++) begin
      a = rand_addr();
      o = rand_off();
      l = rand_len();
      sel = $urandom_range(0, 99);
      if (i != 0) begin
        if (sel < 70) begin
          a = gen_buf_end;
          o = gen_file_end[OFF_W-1:0];
        end else if (sel < 80) begin
          a = gen_buf_end;
        end else if (sel < 88) begin
          o = gen_file_end[OFF_W-1:0];
        end
      end
      add_req(a, l, o, (i == n - 1) && ($urandom_range(0, 19) != 0));
    end
  endtask

  task automatic push_rand(input int cnt);
    int target;
    target = gen_cnt + cnt;
    while (gen_cnt < target) push_rand_list();
  endtask

  task automatic cfg_write(input cfg_reg_t r, input logic v);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.idx   <= r;
    cfg_if.wdata <= v;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    if (r == REG_FILE_OFFSET_MODE) m_fom = v;
    else m_bi = v;
    cfg_if.valid <= 1'b0;
  endtask

  // nothing pending, nothing expected, and the pipeline drained
  task automatic wait_idle();
    do @(negedge clk);
    while (req_pend_q.size() != 0 || req_if.valid || seg_exp_q.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_mode(input logic fom, input logic bi);
    wait_idle();
    cfg_write(REG_FILE_OFFSET_MODE, fom);
    cfg_write(REG_BUFFER_INPUT, bi);
    @(negedge clk);
  endtask

  initial begin
    req_if.valid       = 1'b0;
    req_if.buf_addr    = '0;
    req_if.item_length = '0;
    req_if.file_offset = '0;
    req_if.last_item   = 1'b0;
    seg_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.idx         = REG_FILE_OFFSET_MODE;
    cfg_if.wdata       = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // buffer-only merging, breaks reported as file block
    set_mode(1'b0, 1'b0);
    add_req('1, '1, '1, 1'b1);
    add_req('0, '0, '0, 1'b1);
    add_req(64'h1000, 32'h100, 63'h5000, 1'b0);
    add_req(64'h1100, 32'h200, 63'h9999, 1'b0);
    add_req(64'h8000, 32'h10, 63'h0, 1'b0);
    add_contig(32'h20, 1'b1);
    // buffer end wraps past the top of the address space
    add_req(64'hFFFF_FFFF_FFFF_FF00, 32'h100, 63'h10, 1'b0);
    add_req(64'h0, 32'h40, 63'h20, 1'b1);
    // break on the last request gives two results
    add_req(64'h2000, 32'h4, 63'h1, 1'b0);
    add_req(64'h3000, 32'h8, 63'h2, 1'b1);

    // file offsets must follow too
    set_mode(1'b1, 1'b0);
    add_req(64'h100, 32'h10, 63'h1000, 1'b0);
    add_contig(32'h10, 1'b0);
    add_req(gen_buf_end, 32'h10, 63'h4000, 1'b0);
    add_req(64'hA000, 32'h10, gen_file_end[OFF_W-1:0], 1'b0);
    add_req(64'hB000, 32'h10, 63'h7FFF_FFFF_FFFF_FFF8, 1'b0);
    // file end runs past 63 bits and can never match
    add_contig(32'h4, 1'b1);

    set_mode(1'b0, 1'b1);
    add_req(64'h4000, 32'h8, 63'h0, 1'b0);
    add_req(64'h5000, 32'h8, 63'h8, 1'b0);
    add_contig(32'h8, 1'b1);

    set_mode(1'b1, 1'b1);
    add_req(64'h6000, 32'h8, 63'h100, 1'b0);
    add_req(64'h7000, 32'h8, 63'h108, 1'b0);
    add_contig(32'h0, 1'b1);

    set_mode(1'b1, 1'b1);
    push_rand(150);
    set_mode(1'b0, 1'b0);
    push_rand(150);

    set_mode(1'b1, 1'b0);
    push_rand(150);
    set_mode(1'b0, 1'b1);
    push_rand(150);

    wait_idle();
    repeat (16) @(negedge clk);
    if (seg_exp_q.size() != 0) begin
      $error("%0d expected results never arrived", seg_exp_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("** io_request_coalescer_unit: PASSED **");
    end else begin
      $display("** io_request_coalescer_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** io_request_coalescer_unit: FAILED **");
    $finish;
  end

endmodule

>>> io_request_coalescer_unit.f
hw/rtl/ioc_pkg.sv
hw/rtl/ioc_ifs.sv
hw/rtl/ioc_cfg_regs.sv
hw/rtl/ioc_merge.sv
hw/rtl/ioc_seg_fifo.sv
hw/rtl/io_request_coalescer_unit.sv
sim/testbench.sv
